>>> hw/rtl/lsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_pkg: shared types, constants and functions
// Sector boundaries, register indexes and the update bundle that passes
// from the beam tracker in the top level to the sector bank.
// ----------------------------------------------------------------------------
package lsm_pkg;

	localparam int NUM_SECTORS = 12;
	localparam int SECTOR_W    = 4;
	localparam int ANGLE_W     = 20;
	localparam int CFG_ANGLE_W = 19;
	localparam int CFG_STEP_W  = 17;
	localparam int CFG_DATA_W  = 19;
	localparam int CFG_INDEX_W = 3;
	localparam int RANGE_W     = 16;
	localparam int CM_W        = 8;
	localparam int QUERY_W     = 4;

	typedef logic [SECTOR_W-1:0]       sector_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic [CM_W-1:0]           cm_t;

	// Special sector codes
	localparam sector_t NO_SECTOR          = 4'd15;
	localparam sector_t FRONT_START_SECTOR = 4'd7;
	localparam sector_t REAR_FIRST_SECTOR  = 4'd7;
	localparam sector_t REAR_LAST_SECTOR   = 4'd10;
	localparam cm_t     CM_MAX             = 8'd255;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_FRONT_START = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRONT_STEP  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRONT_STOP  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_REAR_START  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_REAR_STEP   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_REAR_STOP   = 3'd5;

	// Register reset values
	localparam logic signed [CFG_ANGLE_W-1:0] START_RESET = -19'sd148694;
	localparam logic signed [CFG_ANGLE_W-1:0] STOP_RESET  = 19'sd148694;
	localparam logic [CFG_STEP_W-1:0]         STEP_RESET  = 17'd286;

	// Sector boundaries in Q.16 radians, floored (pi = 3.141592)
	localparam angle_t B_POS_30  = 20'sd34314;
	localparam angle_t B_POS_60  = 20'sd68629;
	localparam angle_t B_POS_90  = 20'sd102943;
	localparam angle_t B_POS_120 = 20'sd137258;
	localparam angle_t B_NEG_30  = -20'sd34315;
	localparam angle_t B_NEG_60  = -20'sd68630;
	localparam angle_t B_NEG_90  = -20'sd102944;
	localparam angle_t B_NEG_120 = -20'sd137259;
	localparam angle_t B_ZERO    = 20'sd0;

	// Update request from the beam tracker to the sector bank
	typedef struct packed {
		logic    valid;
		logic    rear;
		logic    first;
		logic    last;
		logic    take;
		sector_t sector;
		cm_t     range_cm;
	} bank_upd_t;

	// Map a front beam angle to its sector, or NO_SECTOR outside the arc
	function automatic sector_t front_sector_of(angle_t a);
		sector_t s;
		priority if (a <= B_NEG_120) s = NO_SECTOR;
		else if (a <= B_NEG_90)      s = 4'd6;
		else if (a <= B_NEG_60)      s = 4'd5;
		else if (a <= B_NEG_30)      s = 4'd4;
		else if (a <= B_ZERO)        s = 4'd3;
		else if (a <= B_POS_30)      s = 4'd2;
		else if (a <= B_POS_60)      s = 4'd1;
		else if (a <= B_POS_90)      s = 4'd0;
		else if (a <= B_POS_120)     s = 4'd11;
		else                         s = NO_SECTOR;
		return s;
	endfunction

	// Map a rear beam angle to its sector; the outer sectors are open-ended
	function automatic sector_t rear_sector_of(angle_t a);
		sector_t s;
		priority if (a > B_POS_30) s = 4'd7;
		else if (a > B_ZERO)       s = 4'd8;
		else if (a > B_NEG_30)     s = 4'd9;
		else                       s = 4'd10;
		return s;
	endfunction

	function automatic logic sector_is_rear(sector_t s);
		return (s >= REAR_FIRST_SECTOR) && (s <= REAR_LAST_SECTOR);
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/lsm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_if: channel interfaces
// Request, response and configuration write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface lsm_req_if import lsm_pkg::*;;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic               scanner_sel;
	logic               first_sample;
	logic               last_sample;
	logic [RANGE_W-1:0] range_mm;
	logic [QUERY_W-1:0] query_index;

	modport source (output valid, req_type, scanner_sel, first_sample, last_sample,
		range_mm, query_index, input ready);
	modport sink (input valid, req_type, scanner_sel, first_sample, last_sample,
		range_mm, query_index, output ready);
endinterface

interface lsm_rsp_if import lsm_pkg::*;;
	logic            valid;
	logic            ready;
	logic [CM_W-1:0] dist_cm;
	logic            query_ok;

	modport source (output valid, dist_cm, query_ok, input ready);
	modport sink (input valid, dist_cm, query_ok, output ready);
endinterface

interface lsm_cfg_if import lsm_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lsm_sector_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_sector_bank: per-sector minima and stored sonar values
// Keeps the running minimum per sector in saturated cm and copies one
// scanner's minima into the stored values at the end of its scan.
// ----------------------------------------------------------------------------
module lsm_sector_bank import lsm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bank_upd_t          upd,
	input  wire logic [QUERY_W-1:0] query_index,
	output logic [CM_W-1:0]         query_value
);

	cm_t min_q [NUM_SECTORS];
	cm_t val_q [NUM_SECTORS];
	cm_t min_next [NUM_SECTORS];

	// Clear on first sample, then fold in this sample's range
	always_comb begin
		for (int s = 0; s < NUM_SECTORS; s++) begin
			min_next[s] = min_q[s];
			if (upd.first && (sector_is_rear(sector_t'(s)) == upd.rear)) begin
				min_next[s] = CM_MAX;
			end
			if (upd.take && (upd.sector == sector_t'(s)) && (upd.range_cm < min_next[s])) begin
				min_next[s] = upd.range_cm;
			end
		end
	end

	// Commit minima; store the scanner's minima on its last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SECTORS; s++) begin
				min_q[s] <= CM_MAX;
				val_q[s] <= CM_MAX;
			end
		end else if (upd.valid) begin
			for (int s = 0; s < NUM_SECTORS; s++) begin
				min_q[s] <= min_next[s];
				if (upd.last && (sector_is_rear(sector_t'(s)) == upd.rear)) begin
					val_q[s] <= min_next[s];
				end
			end
		end
	end

	// Read the stored value; out-of-range index reads zero
	assign query_value = (query_index < QUERY_W'(NUM_SECTORS)) ? val_q[query_index] : '0;

endmodule
`default_nettype wire

>>> hw/rtl/laser_scan_sector_min_to_sonar.sv
`default_nettype none
// ----------------------------------------------------------------------------
// laser_scan_sector_min_to_sonar: laser scan to sonar sector reducer
// Tracks front and rear beam angles, keeps the minimum range per sonar
// sector and answers queries for the stored sector distances.
// ----------------------------------------------------------------------------
// Usage:
//   req  - range samples (req_type 0) and queries (req_type 1). A sample
//          carries scanner_sel, first_sample, last_sample and range_mm; a
//          query carries query_index.
//   rsp  - one transfer per query: dist_cm and query_ok. Samples give none.
//   cfg  - register writes (index 0..5); always ready. Write them only
//          when idle; the block does not enforce it.
// Query path: req, input register, response register, then rsp.
// Throughput: one item per cycle unless stalled. The range to cm multiply
//   sits before the input register; angle step, sector compare and minimum
//   update are one pass behind it, so state is current for the next item.
// Stall: a query held in the input register waits while an untaken response
//   occupies rsp; req.ready drops only in that case, and items behind it
//   wait on req. A sample never waits in the input register.
// Reset: minima and stored values go to 255 cm, both beam angles to zero,
//   the front sector to its start value, registers to their defaults.
// ----------------------------------------------------------------------------
module laser_scan_sector_min_to_sonar import lsm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	lsm_cfg_if.sink   cfg,
	lsm_req_if.sink   req,
	lsm_rsp_if.source rsp
);

	// Configuration registers
	logic signed [CFG_ANGLE_W-1:0] front_start_q, front_stop_q, rear_start_q, rear_stop_q;
	logic [CFG_STEP_W-1:0]         front_step_q, rear_step_q;

	// Input stage
	logic               valid_s1;
	logic               query_s1, rear_s1, first_s1, last_s1;
	cm_t                range_cm_s1;
	logic [QUERY_W-1:0] qidx_s1;

	// Tracker state
	angle_t  front_angle_q, rear_angle_q;
	sector_t front_cur_q;

	// Response register
	logic rsp_valid_q;
	cm_t  rsp_value_q;
	logic rsp_ok_q;

	logic       s1_go, sample_go;
	logic [RANGE_W+CM_W+8:0] range_prod;
	logic [RANGE_W-1:0]      range_cm_full;
	cm_t        range_cm_sat;
	angle_t     front_angle, rear_angle;
	sector_t    front_cur, front_map, front_cur_new, rear_map;
	logic       front_in_arc, rear_in_arc;
	bank_upd_t  upd;
	cm_t        query_value;

	// Accept register writes at once
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_start_q <= START_RESET;
			front_step_q  <= STEP_RESET;
			front_stop_q  <= STOP_RESET;
			rear_start_q  <= START_RESET;
			rear_step_q   <= STEP_RESET;
			rear_stop_q   <= STOP_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_FRONT_START: front_start_q <= cfg.data;
				CFG_FRONT_STEP:  front_step_q  <= cfg.data[CFG_STEP_W-1:0];
				CFG_FRONT_STOP:  front_stop_q  <= cfg.data;
				CFG_REAR_START:  rear_start_q  <= cfg.data;
				CFG_REAR_STEP:   rear_step_q   <= cfg.data[CFG_STEP_W-1:0];
				CFG_REAR_STOP:   rear_stop_q   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Advance the input stage unless a query is blocked by a held response
	assign s1_go     = valid_s1 && (!query_s1 || !rsp_valid_q || rsp.ready);
	assign sample_go = s1_go && !query_s1;
	assign req.ready = !valid_s1 || s1_go;

	// Convert mm to cm by reciprocal multiply (exact for 16-bit ranges), saturate
	assign range_prod    = req.range_mm * 17'd52429;
	assign range_cm_full = RANGE_W'(range_prod[RANGE_W+CM_W+8:19]);
	assign range_cm_sat  = (range_cm_full > RANGE_W'(CM_MAX)) ? CM_MAX
		: range_cm_full[CM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			query_s1    <= req.req_type;
			rear_s1     <= req.scanner_sel;
			first_s1    <= req.first_sample;
			last_s1     <= req.last_sample;
			range_cm_s1 <= range_cm_sat;
			qidx_s1     <= req.query_index;
		end
	end

	// Beam angle and sector for the sample in the input stage
	assign front_angle   = first_s1 ? angle_t'(front_start_q) : front_angle_q;
	assign rear_angle    = first_s1 ? angle_t'(rear_start_q) : rear_angle_q;
	assign front_cur     = first_s1 ? FRONT_START_SECTOR : front_cur_q;
	assign front_in_arc  = front_angle < angle_t'(front_stop_q);
	assign rear_in_arc   = rear_angle < angle_t'(rear_stop_q);
	assign front_map     = front_sector_of(front_angle);
	assign rear_map      = rear_sector_of(rear_angle);
	assign front_cur_new = (front_in_arc && (front_map != NO_SECTOR)) ? front_map : front_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_angle_q <= '0;
			rear_angle_q  <= '0;
			front_cur_q   <= FRONT_START_SECTOR;
		end else if (sample_go) begin
			if (rear_s1) begin
				rear_angle_q <= rear_in_arc
					? rear_angle + $signed({3'b000, rear_step_q}) : rear_angle;
			end else begin
				front_angle_q <= front_in_arc
					? front_angle + $signed({3'b000, front_step_q}) : front_angle;
				front_cur_q   <= front_cur_new;
			end
		end
	end

	// Hand the sample to the sector bank
	always_comb begin
		upd          = '0;
		upd.valid    = sample_go;
		upd.rear     = rear_s1;
		upd.first    = first_s1;
		upd.last     = last_s1;
		upd.range_cm = range_cm_s1;
		if (rear_s1) begin
			upd.take   = rear_in_arc;
			upd.sector = rear_map;
		end else begin
			upd.take   = front_in_arc && !sector_is_rear(front_cur_new);
			upd.sector = front_cur_new;
		end
	end

	lsm_sector_bank u_bank (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (upd),
		.query_index (qidx_s1),
		.query_value (query_value)
	);

	// Load the response on a query; drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_go && query_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && query_s1) begin
			rsp_value_q <= query_value;
			rsp_ok_q    <= qidx_s1 < QUERY_W'(NUM_SECTORS);
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.dist_cm  = rsp_value_q;
	assign rsp.query_ok = rsp_ok_q;

	// An invalid query always reports zero distance
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ok_q) |-> (rsp_value_q == '0))
		else $error("invalid query with nonzero value");

	// The front sector is a front sector or its start value
	assert property (@(posedge clk) disable iff (!arst_n)
		(front_cur_q == FRONT_START_SECTOR) || !sector_is_rear(front_cur_q))
		else $error("front sector holds a rear sector id");

	// A stalled query stays in the input stage untouched
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_go) |=> (valid_s1 && query_s1 && $stable(qidx_s1)))
		else $error("stalled query lost from input stage");

	// A query never overwrites a response that has not been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |-> !(s1_go && query_s1))
		else $error("response overwritten while held");

endmodule
`default_nettype wire
